// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("fail");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("fail");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ----- hw/rtl/lxfc_pkg.sv -----
// Package: types, codes and constants of the link exchange block.
`default_nettype none
package lxfc_pkg;
    localparam int unsigned MAX_BUFFER = 4096;
    localparam int unsigned IN_W = 96;
    localparam int unsigned OUT_W = 80;

    typedef enum logic [1:0] {
        MODE_DISC = 2'd0, MODE_CONN = 2'd1, MODE_HAND = 2'd2, MODE_OPER = 2'd3
    } t_mode;

    localparam logic [2:0] K_DATA = 3'd0, K_CTRL = 3'd1, K_TICK = 3'd2, K_POST = 3'd3,
                           K_TX = 3'd4, K_ATTACH = 3'd5, K_DETACH = 3'd6;
    localparam logic [2:0] SYM_HS1 = 3'd0, SYM_HS2 = 3'd1, SYM_START = 3'd2,
                           SYM_END = 3'd3, SYM_EEP = 3'd4, SYM_FCT = 3'd5,
                           SYM_KAT = 3'd6;
    localparam logic [3:0] EV_NONE = 4'd0, EV_CTRL = 4'd1, EV_STORE = 4'd2,
                           EV_DONE = 4'd3, EV_GRANT = 4'd4, EV_WAIT = 4'd5,
                           EV_DISC = 4'd6, EV_BUFOK = 4'd7, EV_BUFWAIT = 4'd8,
                           EV_RESET = 4'd9;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  rx_symbol;
        logic [31:0] rx_param;
        logic [7:0]  data_byte;
        logic [12:0] buffer_limit;
        logic [30:0] handshake_nonce;
    } t_in;

    typedef struct packed {
        logic [3:0]  event_res;
        logic [2:0]  tx_symbol;
        logic [31:0] tx_param;
        logic [11:0] store_address;
        logic [7:0]  store_value;
        logic [15:0] packet_length;
        logic        truncated;
    } t_res;

    typedef struct packed {
        logic [1:0] count;
        t_res       r0;
        t_res       r1;
        t_res       r2;
        logic       restart;
        t_mode      mode;
    } t_batch;

    function automatic t_res mk(logic [3:0] ev, logic [2:0] sym, logic [31:0] prm);
        t_res r;
        r = '0;
        r.event_res = ev;
        r.tx_symbol = sym;
        r.tx_param = prm;
        return r;
    endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/lxfc_engine.sv -----
// Protocol state and per-word result computation.
`default_nettype none
module lxfc_engine (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_go,
    input  wire lxfc_pkg::t_in   i_item,
    output lxfc_pkg::t_batch     o_batch,
    output lxfc_pkg::t_mode      o_mode
);
    lxfc_pkg::t_mode r_mode, n_mode;
    logic [31:0] r_hsid, n_hsid, r_cs, n_cs, r_cr, n_cr, r_ps, n_ps, r_pr, n_pr;
    logic r_posted, n_posted, r_recv, n_recv;
    logic [12:0] r_lim, n_lim;
    logic [15:0] r_off, n_off;
    lxfc_pkg::t_res q0, q1, q2;
    logic [1:0] cnt;
    logic restart;
    logic [12:0] clim;

    assign o_mode = r_mode;

    always_comb begin
        lxfc_pkg::t_res rr;
        logic viol;
        n_mode = r_mode; n_hsid = r_hsid; n_cs = r_cs; n_cr = r_cr; n_ps = r_ps;
        n_pr = r_pr; n_posted = r_posted; n_recv = r_recv; n_lim = r_lim; n_off = r_off;
        q0 = '0; q1 = '0; q2 = '0; cnt = 2'd0; restart = 1'b0; viol = 1'b0; rr = '0;
        clim = (i_item.buffer_limit > 13'(lxfc_pkg::MAX_BUFFER)) ?
               13'(lxfc_pkg::MAX_BUFFER) : i_item.buffer_limit;
        if (clim > 13'd4096) clim = 13'd4096;
        case (i_item.kind)
            lxfc_pkg::K_DATA: begin
                if (r_mode == lxfc_pkg::MODE_OPER) begin
                    if (!r_recv) viol = 1'b1;
                    else begin
                        if ({3'd0, r_off} < 19'(r_lim) ) begin
                            rr = '0;
                            rr.event_res = lxfc_pkg::EV_STORE;
                            rr.store_address = r_off[11:0];
                            rr.store_value = i_item.data_byte;
                            q0 = rr; cnt = 2'd1;
                        end
                        if (r_off != 16'hFFFF) n_off = r_off + 16'd1;
                    end
                end else if (r_mode != lxfc_pkg::MODE_DISC) viol = 1'b1;
            end
            lxfc_pkg::K_CTRL: begin
                if (r_mode == lxfc_pkg::MODE_CONN) begin
                    if (i_item.rx_symbol == lxfc_pkg::SYM_HS1) begin
                        q0 = lxfc_pkg::mk(lxfc_pkg::EV_CTRL, lxfc_pkg::SYM_HS2,
                                          i_item.rx_param);
                        cnt = 2'd1; n_mode = lxfc_pkg::MODE_OPER; restart = 1'b1;
                    end else viol = 1'b1;
                end else if (r_mode == lxfc_pkg::MODE_HAND) begin
                    if (i_item.rx_symbol == lxfc_pkg::SYM_HS2 && i_item.rx_param == r_hsid)
                        n_mode = lxfc_pkg::MODE_OPER;
                    else viol = 1'b1;
                end else if (r_mode == lxfc_pkg::MODE_OPER) begin
                    case (i_item.rx_symbol)
                        lxfc_pkg::SYM_HS1: viol = 1'b1;
                        lxfc_pkg::SYM_START:
                            if (r_cs != r_pr + 32'd1 || !r_posted || r_recv) viol = 1'b1;
                            else begin n_recv = 1'b1; n_pr = r_pr + 32'd1; end
                        lxfc_pkg::SYM_END:
                            if (!r_recv) viol = 1'b1;
                            else begin
                                rr = '0;
                                rr.event_res = lxfc_pkg::EV_DONE;
                                rr.packet_length = r_off;
                                rr.truncated = r_off > {3'd0, r_lim};
                                q0 = rr; cnt = 2'd1; n_recv = 1'b0; n_posted = 1'b0;
                            end
                        lxfc_pkg::SYM_EEP:
                            if (!r_recv) viol = 1'b1; else n_off = '0;
                        lxfc_pkg::SYM_FCT:
                            if (i_item.rx_param == r_cr + 32'd1) begin
                                if (r_ps != r_cr) viol = 1'b1; else n_cr = i_item.rx_param;
                            end else if (i_item.rx_param != r_cr) viol = 1'b1;
                        lxfc_pkg::SYM_KAT:
                            if (r_pr != i_item.rx_param) viol = 1'b1;
                        default: viol = 1'b1;
                    endcase
                end
            end
            lxfc_pkg::K_TICK: begin
                if (r_mode == lxfc_pkg::MODE_CONN || r_mode == lxfc_pkg::MODE_HAND) begin
                    n_hsid = {1'b1, i_item.handshake_nonce};
                    n_mode = lxfc_pkg::MODE_HAND;
                    q0 = lxfc_pkg::mk(lxfc_pkg::EV_CTRL, lxfc_pkg::SYM_HS1,
                                      {1'b1, i_item.handshake_nonce});
                    cnt = 2'd1; restart = 1'b1;
                end else if (r_mode == lxfc_pkg::MODE_OPER) begin
                    q0 = lxfc_pkg::mk(lxfc_pkg::EV_CTRL, lxfc_pkg::SYM_FCT, r_cs);
                    q1 = lxfc_pkg::mk(lxfc_pkg::EV_CTRL, lxfc_pkg::SYM_KAT, r_ps);
                    cnt = 2'd2; restart = 1'b1;
                end
            end
            lxfc_pkg::K_POST: begin
                cnt = 2'd1;
                if (r_mode == lxfc_pkg::MODE_DISC)
                    q0 = lxfc_pkg::mk(lxfc_pkg::EV_DISC, 3'd0, 32'd0);
                else if (r_mode != lxfc_pkg::MODE_OPER || r_posted || r_recv || r_cs != r_pr)
                    q0 = lxfc_pkg::mk(lxfc_pkg::EV_BUFWAIT, 3'd0, 32'd0);
                else begin
                    n_posted = 1'b1; n_lim = clim; n_off = '0; n_cs = r_cs + 32'd1;
                    q0 = lxfc_pkg::mk(lxfc_pkg::EV_BUFOK, 3'd0, 32'd0);
                    q1 = lxfc_pkg::mk(lxfc_pkg::EV_CTRL, lxfc_pkg::SYM_FCT, r_cs + 32'd1);
                    q2 = lxfc_pkg::mk(lxfc_pkg::EV_CTRL, lxfc_pkg::SYM_KAT, r_ps);
                    cnt = 2'd3; restart = 1'b1;
                end
            end
            lxfc_pkg::K_TX: begin
                cnt = 2'd1;
                if (r_mode == lxfc_pkg::MODE_DISC)
                    q0 = lxfc_pkg::mk(lxfc_pkg::EV_DISC, 3'd0, 32'd0);
                else if (r_mode == lxfc_pkg::MODE_OPER && r_ps != r_cr) begin
                    n_ps = r_ps + 32'd1;
                    q0 = lxfc_pkg::mk(lxfc_pkg::EV_GRANT, 3'd0, 32'd0);
                end else q0 = lxfc_pkg::mk(lxfc_pkg::EV_WAIT, 3'd0, 32'd0);
            end
            lxfc_pkg::K_ATTACH:
                if (r_mode == lxfc_pkg::MODE_DISC) begin viol = 1'b1; restart = 1'b1; end
            lxfc_pkg::K_DETACH: begin
                n_mode = lxfc_pkg::MODE_DISC; n_posted = 1'b0; n_recv = 1'b0;
                q0 = lxfc_pkg::mk(lxfc_pkg::EV_DISC, 3'd0, 32'd0); cnt = 2'd1;
            end
            default: ;
        endcase
        if (viol) begin
            n_mode = lxfc_pkg::MODE_CONN; n_hsid = '0; n_cs = '0; n_cr = '0; n_ps = '0;
            n_pr = '0; n_posted = 1'b0; n_recv = 1'b0; n_lim = '0; n_off = '0;
            q0 = lxfc_pkg::mk(lxfc_pkg::EV_RESET, 3'd0, 32'd0); cnt = 2'd1;
            if (i_item.kind == lxfc_pkg::K_CTRL && r_mode == lxfc_pkg::MODE_OPER &&
                i_item.rx_symbol == lxfc_pkg::SYM_HS1) begin
                q1 = lxfc_pkg::mk(lxfc_pkg::EV_CTRL, lxfc_pkg::SYM_HS2, i_item.rx_param);
                cnt = 2'd2; n_mode = lxfc_pkg::MODE_OPER; restart = 1'b1;
            end
        end
        if (cnt == 2'd0) begin q0 = '0; cnt = 2'd1; end
    end

    always_comb begin
        o_batch.count = cnt;
        o_batch.r0 = q0;
        o_batch.r1 = q1;
        o_batch.r2 = q2;
        o_batch.restart = restart;
        o_batch.mode = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= lxfc_pkg::MODE_DISC;
            r_hsid <= '0; r_cs <= '0; r_cr <= '0; r_ps <= '0; r_pr <= '0;
            r_posted <= 1'b0; r_recv <= 1'b0; r_lim <= '0; r_off <= '0;
        end else if (i_go) begin
            r_mode <= n_mode;
            r_hsid <= n_hsid; r_cs <= n_cs; r_cr <= n_cr; r_ps <= n_ps; r_pr <= n_pr;
            r_posted <= n_posted; r_recv <= n_recv; r_lim <= n_lim; r_off <= n_off;
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/lxfc_outq.sv -----
// Result register: holds one word's results and serializes them.
`default_nettype none
module lxfc_outq (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire lxfc_pkg::t_batch i_batch,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic                  o_room,
    output logic [lxfc_pkg::OUT_W-1:0] o_data,
    output logic                  o_last
);
    lxfc_pkg::t_batch r_b;
    logic [1:0] r_idx, r_left;
    lxfc_pkg::t_res cur;

    assign o_valid = (r_left != 2'd0);
    assign o_last = (r_left == 2'd1);
    assign o_room = (r_left == 2'd0) || (r_left == 2'd1 && i_pop);

    always_comb begin
        case (r_idx)
            2'd0: cur = r_b.r0;
            2'd1: cur = r_b.r1;
            default: cur = r_b.r2;
        endcase
        o_data = {1'b0, r_b.mode, r_b.restart, cur.truncated, cur.packet_length,
                  cur.store_value, cur.store_address, cur.tx_param, cur.tx_symbol,
                  cur.event_res};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 2'd0;
            r_idx <= 2'd0;
        end else if (i_load) begin
            r_left <= i_batch.count;
            r_idx <= 2'd0;
        end else if (i_pop && o_valid) begin
            r_left <= r_left - 2'd1;
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) r_b <= i_batch;
    end
endmodule
`default_nettype wire

// ----- hw/rtl/link_exchange_flow_control_core.sv -----
// Top level of the link exchange and credit flow control block.
// Results are registered and appear in the cycle after a word is accepted; up to three per word.
// Throughput: one word per cycle when it causes one result and m_axis_tready is high; a word
// yielding N results occupies the result register until all N are taken by the single output port.
// Reset: synchronous active-low i_rst_n puts the link in disconnected with counters zero
// and the result register empty.
`default_nettype none
`include "assert_macros.svh"
module link_exchange_flow_control_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // kind, rx_symbol, rx_param, data_byte, buffer_limit, handshake_nonce (lsb up)
    input  wire logic [lxfc_pkg::IN_W-1:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // event_res, tx_symbol, tx_param, store_address, store_value, packet_length,
    // truncated, restart_interval, link_state (lsb up)
    output logic [lxfc_pkg::OUT_W-1:0] m_axis_tdata,
    output logic             m_axis_tlast
);
    lxfc_pkg::t_in in_item;
    lxfc_pkg::t_batch batch;
    lxfc_pkg::t_mode mode;
    logic go, room;

    assign in_item.kind = s_axis_tdata[2:0];
    assign in_item.rx_symbol = s_axis_tdata[5:3];
    assign in_item.rx_param = s_axis_tdata[37:6];
    assign in_item.data_byte = s_axis_tdata[45:38];
    assign in_item.buffer_limit = s_axis_tdata[58:46];
    assign in_item.handshake_nonce = s_axis_tdata[89:59];

    assign s_axis_tready = room;
    assign go = s_axis_tvalid && room;

    lxfc_engine u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(go), .i_item(in_item),
        .o_batch(batch), .o_mode(mode)
    );

    lxfc_outq u_outq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(go), .i_batch(batch),
        .i_pop(m_axis_tready), .o_valid(m_axis_tvalid), .o_room(room),
        .o_data(m_axis_tdata), .o_last(m_axis_tlast)
    );

    `ASSERT_NEXT(a_load_valid, i_clk, i_rst_n, go, m_axis_tvalid)
    `ASSERT_IMPLIES(a_state_match, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast,
        m_axis_tdata[78:77] == mode)
    `ASSERT_IMPLIES(a_no_take_busy, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tlast, !s_axis_tready)
endmodule
`default_nettype wire

// ----- tb/tb_link_exchange_flow_control_core.sv -----
// Testbench of the link exchange core: directed and random words against a built-in predictor.
`default_nettype none
module tb_link_exchange_flow_control_core;

    typedef struct {
        logic [3:0]  ev;
        logic [2:0]  sym;
        logic [31:0] prm;
        logic [11:0] addr;
        logic [7:0]  val;
        logic [15:0] len;
        logic        trunc;
        logic        restart;
        logic [1:0]  mode;
        logic        last;
    } t_exp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic        m_axis_tlast;

    link_exchange_flow_control_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    logic [95:0] pending_words[$];
    t_exp        expected_results[$];
    int          errors = 0;
    bit          stim_done = 0;
    bit          no_idle = 0;
    bit          hold_off = 0;
    int          idle_cycles = 0;

    // link predictor state
    lxfc_pkg::t_mode lk_mode = lxfc_pkg::MODE_DISC;
    logic [31:0] lk_hs_id, lk_cred_tx, lk_cred_rx, lk_pkt_tx, lk_pkt_rx;
    logic        lk_posted, lk_receiving;
    logic [12:0] lk_limit;
    logic [15:0] lk_offset;
    t_exp        step_res[$];

    function automatic logic [95:0] pack_word(logic [2:0] kind, logic [2:0] sym,
            logic [31:0] prm, logic [7:0] b, logic [12:0] lim, logic [30:0] nonce);
        return {6'd0, nonce, lim, b, prm, sym, kind};
    endfunction

    task automatic emit(logic [3:0] ev, logic [2:0] sym, logic [31:0] prm,
            logic [11:0] addr = 0, logic [7:0] val = 0, logic [15:0] len = 0,
            logic trunc = 0);
        t_exp r;
        if (step_res.size() >= 3) return;
        r.ev = ev; r.sym = sym; r.prm = prm; r.addr = addr; r.val = val;
        r.len = len; r.trunc = trunc; r.restart = 0; r.mode = 0; r.last = 0;
        step_res.push_back(r);
    endtask

    task automatic link_clear();
        lk_mode = lxfc_pkg::MODE_CONN; lk_hs_id = 0; lk_cred_tx = 0; lk_cred_rx = 0;
        lk_pkt_tx = 0; lk_pkt_rx = 0; lk_posted = 0; lk_receiving = 0;
        lk_limit = 0; lk_offset = 0;
    endtask

    task automatic link_fault();
        link_clear();
        emit(lxfc_pkg::EV_RESET, 0, 0);
    endtask

    task automatic send_tokens();
        emit(lxfc_pkg::EV_CTRL, lxfc_pkg::SYM_FCT, lk_cred_tx);
        emit(lxfc_pkg::EV_CTRL, lxfc_pkg::SYM_KAT, lk_pkt_tx);
    endtask

    task automatic predict_ctrl(logic [2:0] sym, logic [31:0] prm, output bit restart);
        restart = 0;
        if (lk_mode == lxfc_pkg::MODE_DISC) return;
        if (lk_mode == lxfc_pkg::MODE_CONN) begin
            if (sym == lxfc_pkg::SYM_HS1) begin
                emit(lxfc_pkg::EV_CTRL, lxfc_pkg::SYM_HS2, prm);
                lk_mode = lxfc_pkg::MODE_OPER;
                restart = 1;
            end else link_fault();
            return;
        end
        if (lk_mode == lxfc_pkg::MODE_HAND) begin
            if (sym == lxfc_pkg::SYM_HS2 && prm == lk_hs_id) lk_mode = lxfc_pkg::MODE_OPER;
            else link_fault();
            return;
        end
        case (sym)
            lxfc_pkg::SYM_HS1: begin
                link_fault();
                emit(lxfc_pkg::EV_CTRL, lxfc_pkg::SYM_HS2, prm);
                lk_mode = lxfc_pkg::MODE_OPER;
                restart = 1;
            end
            lxfc_pkg::SYM_START: begin
                if (lk_cred_tx != lk_pkt_rx + 1 || !lk_posted || lk_receiving) link_fault();
                else begin
                    lk_receiving = 1;
                    lk_pkt_rx++;
                end
            end
            lxfc_pkg::SYM_END: begin
                if (!lk_receiving) link_fault();
                else begin
                    emit(lxfc_pkg::EV_DONE, 0, 0, 0, 0, lk_offset, lk_offset > lk_limit);
                    lk_receiving = 0;
                    lk_posted = 0;
                end
            end
            lxfc_pkg::SYM_EEP: begin
                if (!lk_receiving) link_fault();
                else lk_offset = 0;
            end
            lxfc_pkg::SYM_FCT: begin
                if (prm == lk_cred_rx + 1) begin
                    if (lk_pkt_tx != lk_cred_rx) link_fault();
                    else lk_cred_rx = prm;
                end else if (prm != lk_cred_rx) link_fault();
            end
            lxfc_pkg::SYM_KAT: if (lk_pkt_rx != prm) link_fault();
            default: link_fault();
        endcase
    endtask

    task automatic predict_link(logic [95:0] w);
        logic [2:0]  kind, sym;
        logic [31:0] prm;
        logic [7:0]  b;
        logic [12:0] lim;
        logic [30:0] nonce;
        bit          restart;
        kind = w[2:0]; sym = w[5:3]; prm = w[37:6]; b = w[45:38];
        lim = w[58:46]; nonce = w[89:59];
        restart = 0;
        step_res.delete();
        case (kind)
            lxfc_pkg::K_DATA: begin
                if (lk_mode == lxfc_pkg::MODE_OPER) begin
                    if (!lk_receiving) link_fault();
                    else begin
                        if (lk_offset < lk_limit)
                            emit(lxfc_pkg::EV_STORE, 0, 0, lk_offset[11:0], b);
                        if (lk_offset != 16'hFFFF) lk_offset++;
                    end
                end else if (lk_mode != lxfc_pkg::MODE_DISC) link_fault();
            end
            lxfc_pkg::K_CTRL: predict_ctrl(sym, prm, restart);
            lxfc_pkg::K_TICK: begin
                if (lk_mode == lxfc_pkg::MODE_CONN || lk_mode == lxfc_pkg::MODE_HAND) begin
                    lk_hs_id = {1'b1, nonce};
                    lk_mode = lxfc_pkg::MODE_HAND;
                    emit(lxfc_pkg::EV_CTRL, lxfc_pkg::SYM_HS1, lk_hs_id);
                    restart = 1;
                end else if (lk_mode == lxfc_pkg::MODE_OPER) begin
                    send_tokens();
                    restart = 1;
                end
            end
            lxfc_pkg::K_POST: begin
                if (lk_mode == lxfc_pkg::MODE_DISC) emit(lxfc_pkg::EV_DISC, 0, 0);
                else if (lk_mode != lxfc_pkg::MODE_OPER || lk_posted || lk_receiving ||
                         lk_cred_tx != lk_pkt_rx) emit(lxfc_pkg::EV_BUFWAIT, 0, 0);
                else begin
                    if (lim > lxfc_pkg::MAX_BUFFER) lim = 13'(lxfc_pkg::MAX_BUFFER);
                    if (lim > 4096) lim = 13'd4096;
                    lk_posted = 1; lk_limit = lim; lk_offset = 0; lk_cred_tx++;
                    emit(lxfc_pkg::EV_BUFOK, 0, 0);
                    send_tokens();
                    restart = 1;
                end
            end
            lxfc_pkg::K_TX: begin
                if (lk_mode == lxfc_pkg::MODE_DISC) emit(lxfc_pkg::EV_DISC, 0, 0);
                else if (lk_mode == lxfc_pkg::MODE_OPER && lk_pkt_tx != lk_cred_rx) begin
                    lk_pkt_tx++;
                    emit(lxfc_pkg::EV_GRANT, 0, 0);
                end else emit(lxfc_pkg::EV_WAIT, 0, 0);
            end
            lxfc_pkg::K_ATTACH: if (lk_mode == lxfc_pkg::MODE_DISC) begin
                link_fault();
                restart = 1;
            end
            lxfc_pkg::K_DETACH: begin
                lk_mode = lxfc_pkg::MODE_DISC; lk_posted = 0; lk_receiving = 0;
                emit(lxfc_pkg::EV_DISC, 0, 0);
            end
            default: ;
        endcase
        if (step_res.size() == 0) emit(lxfc_pkg::EV_NONE, 0, 0);
        foreach (step_res[k]) begin
            step_res[k].restart = restart;
            step_res[k].mode = lk_mode;
            step_res[k].last = (k == step_res.size() - 1);
            expected_results.push_back(step_res[k]);
        end
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            predict_link(s_axis_tdata);
            void'(pending_words.pop_front());
            if (pending_words.size() > 0 && (no_idle || $urandom_range(99) >= 10)) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= pending_words[0];
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end else if (!s_axis_tvalid && pending_words.size() > 0 &&
                     (no_idle || $urandom_range(99) >= 10)) begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= pending_words[0];
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_exp e;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                idle_cycles <= 0;
                if (expected_results.size() == 0) begin
                    $display("unexpected word %0h at %0t", m_axis_tdata, $time);
                    errors++;
                end else begin
                    e = expected_results.pop_front();
                    if (m_axis_tdata[3:0] != e.ev) report("event", m_axis_tdata[3:0], e.ev);
                    if (m_axis_tdata[6:4] != e.sym) report("tx_symbol", m_axis_tdata[6:4], e.sym);
                    if (m_axis_tdata[38:7] != e.prm) report("tx_param", m_axis_tdata[38:7], e.prm);
                    if (m_axis_tdata[50:39] != e.addr) report("address", m_axis_tdata[50:39], e.addr);
                    if (m_axis_tdata[58:51] != e.val) report("value", m_axis_tdata[58:51], e.val);
                    if (m_axis_tdata[74:59] != e.len) report("length", m_axis_tdata[74:59], e.len);
                    if (m_axis_tdata[75] != e.trunc) report("truncated", m_axis_tdata[75], e.trunc);
                    if (m_axis_tdata[76] != e.restart) report("restart", m_axis_tdata[76], e.restart);
                    if (m_axis_tdata[78:77] != e.mode) report("state", m_axis_tdata[78:77], e.mode);
                    if (m_axis_tlast != e.last) report("tlast", m_axis_tlast, e.last);
                end
            end else if (s_axis_tvalid && s_axis_tready) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            m_axis_tready <= !hold_off && (no_idle || $urandom_range(99) >= 10);
        end
    end

    task automatic add(logic [2:0] kind, logic [2:0] sym = 0, logic [31:0] prm = 0,
            logic [7:0] b = 0, logic [12:0] lim = 0);
        pending_words.push_back(pack_word(kind, sym, prm, b, lim, 31'($urandom)));
    endtask

    task automatic wait_drained();
        while (pending_words.size() > 0 || expected_results.size() > 0) @(posedge i_clk);
    endtask

    // connect as responder, post a buffer, receive one packet of random bytes, then exchange tokens
    task automatic add_session(int nbytes, logic [12:0] lim, bit attach);
        if (attach) add(lxfc_pkg::K_ATTACH);
        add(lxfc_pkg::K_CTRL, lxfc_pkg::SYM_HS1, $urandom);
        add(lxfc_pkg::K_POST, 0, 0, 0, lim);
        add(lxfc_pkg::K_CTRL, lxfc_pkg::SYM_START);
        repeat (nbytes) add(lxfc_pkg::K_DATA, 0, 0, 8'($urandom));
        if ($urandom_range(3) == 0) add(lxfc_pkg::K_CTRL, lxfc_pkg::SYM_EEP);
        add(lxfc_pkg::K_CTRL, lxfc_pkg::SYM_END);
        add(lxfc_pkg::K_CTRL, lxfc_pkg::SYM_FCT, 1);
        add(lxfc_pkg::K_TX);
        add(lxfc_pkg::K_TX);
        add(lxfc_pkg::K_CTRL, lxfc_pkg::SYM_KAT, 1);
        add(lxfc_pkg::K_TICK);
    endtask

    initial begin
        int n;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed
        add(lxfc_pkg::K_DATA); add(lxfc_pkg::K_CTRL, lxfc_pkg::SYM_HS1);
        add(lxfc_pkg::K_TICK); add(lxfc_pkg::K_POST); add(lxfc_pkg::K_TX);
        add(lxfc_pkg::K_DETACH);
        add(lxfc_pkg::K_ATTACH); add(lxfc_pkg::K_ATTACH); add(lxfc_pkg::K_POST);
        add(lxfc_pkg::K_TX);
        add(lxfc_pkg::K_TICK); add(lxfc_pkg::K_TICK);
        add(lxfc_pkg::K_CTRL, lxfc_pkg::SYM_HS2, 32'h1234);
        add(lxfc_pkg::K_ATTACH); add(lxfc_pkg::K_DATA);
        add(3'd7); add(lxfc_pkg::K_DETACH);
        add_session(4, 13'h1FFF, 1);
        add(lxfc_pkg::K_CTRL, lxfc_pkg::SYM_HS1, 32'hFFFFFFFF);
        add(lxfc_pkg::K_POST, 0, 0, 0, 2); add(lxfc_pkg::K_POST, 0, 0, 0, 2);
        add(lxfc_pkg::K_CTRL, lxfc_pkg::SYM_START);
        add(lxfc_pkg::K_DATA, 0, 0, 8'hFF); add(lxfc_pkg::K_DATA, 0, 0, 8'h00);
        add(lxfc_pkg::K_DATA); add(lxfc_pkg::K_CTRL, lxfc_pkg::SYM_END);
        add(lxfc_pkg::K_CTRL, 3'd7);
        wait_drained();
        // handshake as initiator
        add(lxfc_pkg::K_TICK);
        wait_drained();
        add(lxfc_pkg::K_CTRL, lxfc_pkg::SYM_HS2, lk_hs_id);
        add(lxfc_pkg::K_DETACH);
        // long receiver hold-off with a full input stream
        add_session(20, 8, 1);
        hold_off = 1;
        repeat (60) @(posedge i_clk);
        hold_off = 0;
        wait_drained();
        // random: mostly well-formed sessions, some noise
        n = 0;
        while (n < 170) begin
            if (n > 100 && n < 160) no_idle = 1; else no_idle = 0;
            if ($urandom_range(9) < 7) begin
                add_session($urandom_range(0, 6), $urandom_range(0, 9) == 0 ?
                            13'($urandom) : 13'($urandom_range(0, 5)),
                            1'($urandom_range(1)));
                n += 12;
            end else begin
                add(3'($urandom_range(0, 7)), 3'($urandom), $urandom_range(1) ? $urandom :
                    $urandom_range(0, 2), 8'($urandom), 13'($urandom));
                n++;
            end
            if ($urandom_range(7) == 0) wait_drained();
        end
        wait_drained();
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("tb_link_exchange_flow_control_core passed");
        else
            $display("tb_link_exchange_flow_control_core failed");
        $finish;
    end

    initial begin
        wait (idle_cycles >= 2000);
        $display("tb_link_exchange_flow_control_core failed");
        $finish;
    end
endmodule
`default_nettype wire
